>>> design/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length prefix frame decoder.
// ----------------------------------------------------------------------------
package lpfd_pkg;

	localparam int LEN_BITS_DEFAULT = 16;
	localparam int BYTE_W           = 8;
	localparam int PADDR_W          = 2;
	localparam int PDATA_W          = 32;

	localparam logic [BYTE_W-1:0]  SEPARATOR_RESET = 8'h21;
	localparam logic [BYTE_W-1:0]  CHAR_ZERO       = 8'h30;
	localparam logic [BYTE_W-1:0]  CHAR_NINE       = 8'h39;
	localparam logic [PADDR_W-1:0] ADDR_SEPARATOR  = 2'd0;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              has_data;
		logic              end_of_string;
		logic              format_error;
	} result_t;

endpackage

>>> design/lpfd_if.sv
// ----------------------------------------------------------------------------
// lpfd_in_if / lpfd_out_if
// Valid/ready channels carrying stream bytes in and decoded items out.
// ----------------------------------------------------------------------------
interface lpfd_in_if;
	import lpfd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpfd_out_if;
	import lpfd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              has_data;
	logic              end_of_string;
	logic              format_error;

	modport source (output valid, output out_byte, output has_data, output end_of_string,
		output format_error, input ready);
	modport sink   (input valid, input out_byte, input has_data, input end_of_string,
		input format_error, output ready);
endinterface

>>> design/lpfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpfd_cfg_regs
// APB register block holding the separator character.
// ----------------------------------------------------------------------------
module lpfd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpfd_pkg::PADDR_W-1:0]  paddr,
	input  logic [lpfd_pkg::PDATA_W-1:0]  pwdata,
	output logic [lpfd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [lpfd_pkg::BYTE_W-1:0]   separator_char
);
	import lpfd_pkg::*;

	logic [BYTE_W-1:0] separator_q;
	logic              wr_sep;

	assign pready = 1'b1;
	assign wr_sep = psel && penable && pwrite && (paddr == ADDR_SEPARATOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= SEPARATOR_RESET;
		end else if (wr_sep) begin
			separator_q <= pwdata[BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr)
			ADDR_SEPARATOR: prdata = {{(PDATA_W-BYTE_W){1'b0}}, separator_q};
			default:        prdata = '0;
		endcase
	end

	assign separator_char = separator_q;
endmodule

>>> design/lpfd_parse.sv
// ----------------------------------------------------------------------------
// lpfd_parse
// Framing state and per-byte decode: length digits, separator, payload count.
// ----------------------------------------------------------------------------
module lpfd_parse #(
	parameter int LEN_BITS = lpfd_pkg::LEN_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [lpfd_pkg::BYTE_W-1:0]  in_byte,
	input  logic [lpfd_pkg::BYTE_W-1:0]  separator_char,
	output logic                         emit,
	output lpfd_pkg::result_t            result
);
	import lpfd_pkg::*;

	localparam int EXT_W = LEN_BITS + 4;

	logic                in_payload_q;
	logic [LEN_BITS-1:0] length_accum_q;
	logic [LEN_BITS-1:0] bytes_left_q;

	logic                in_payload_d;
	logic [LEN_BITS-1:0] length_accum_d;
	logic [LEN_BITS-1:0] bytes_left_d;

	logic                is_digit;
	logic                last;
	logic [EXT_W-1:0]    acc_ext;
	logic [EXT_W-1:0]    next_len;
	logic                overflow;

	assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
	assign last     = (bytes_left_q <= LEN_BITS'(1));
	assign acc_ext  = EXT_W'(length_accum_q);
	// length*10 + digit as two shifts and adds
	assign next_len = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(in_byte[3:0]);
	assign overflow = |next_len[EXT_W-1:LEN_BITS];

	always_comb begin
		in_payload_d   = in_payload_q;
		length_accum_d = length_accum_q;
		bytes_left_d   = bytes_left_q;
		emit           = 1'b0;
		result         = '0;
		if (in_payload_q) begin
			emit                 = 1'b1;
			result.out_byte      = in_byte;
			result.has_data      = 1'b1;
			result.end_of_string = last;
			if (last) begin
				bytes_left_d = '0;
				in_payload_d = 1'b0;
			end else begin
				bytes_left_d = bytes_left_q - LEN_BITS'(1);
			end
		end else if (in_byte == separator_char) begin
			if (length_accum_q == '0) begin
				emit                 = 1'b1;
				result.end_of_string = 1'b1;
			end else begin
				bytes_left_d   = length_accum_q;
				length_accum_d = '0;
				in_payload_d   = 1'b1;
			end
		end else if (is_digit && !overflow) begin
			length_accum_d = next_len[LEN_BITS-1:0];
		end else begin
			// bad length character or overflow
			length_accum_d      = '0;
			emit                = 1'b1;
			result.format_error = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q   <= 1'b0;
			length_accum_q <= '0;
			bytes_left_q   <= '0;
		end else if (step) begin
			in_payload_q   <= in_payload_d;
			length_accum_q <= length_accum_d;
			bytes_left_q   <= bytes_left_d;
		end
	end
endmodule

>>> design/lpfd_out_reg.sv
// ----------------------------------------------------------------------------
// lpfd_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module lpfd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  lpfd_pkg::result_t  result,
	output logic               free,
	lpfd_out_if.source         out_ch
);
	import lpfd_pkg::*;

	logic    valid_s2;
	result_t result_s2;

	assign free = !valid_s2 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			result_s2 <= result;
		end
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.out_byte      = result_s2.out_byte;
	assign out_ch.has_data      = result_s2.has_data;
	assign out_ch.end_of_string = result_s2.end_of_string;
	assign out_ch.format_error  = result_s2.format_error;
endmodule

>>> design/length_prefix_frame_decoder.sv
// ----------------------------------------------------------------------------
// length_prefix_frame_decoder
// Path: a byte accepted into the input register passes the decode step into
// the result register, where its result can be taken (input register, then
// result register). Throughput: one byte per cycle, set by the single decode
// step between the two registers; stalls only on output backpressure.
// Reset clears the framing state and both valid flags; separator returns to '!'.
// ----------------------------------------------------------------------------
module length_prefix_frame_decoder #(
	parameter int LEN_BITS = lpfd_pkg::LEN_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lpfd_pkg::PADDR_W-1:0] paddr,
	input  logic [lpfd_pkg::PDATA_W-1:0] pwdata,
	output logic [lpfd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	lpfd_in_if.sink                      in_ch,
	lpfd_out_if.source                   out_ch
);
	import lpfd_pkg::*;

	logic [BYTE_W-1:0] separator_char;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              step;
	logic              emit;
	result_t           result;

	lpfd_cfg_regs u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.separator_char (separator_char)
	);

	// item in the input register moves on when the result register has room
	assign step        = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.in_byte;
		end
	end

	lpfd_parse #(
		.LEN_BITS (LEN_BITS)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.in_byte        (byte_s1),
		.separator_char (separator_char),
		.emit           (emit),
		.result         (result)
	);

	lpfd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && emit),
		.result (result),
		.free   (out_free),
		.out_ch (out_ch)
	);
endmodule

>>> dv/length_prefix_frame_decoder_checker.sv
// ----------------------------------------------------------------------------
// length_prefix_frame_decoder_checker
// Watches the config port and both channels, decodes every accepted stream
// byte with its own copy of the framing state and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefix_frame_decoder_checker #(
	parameter int LEN_BITS = lpfd_pkg::LEN_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [lpfd_pkg::PADDR_W-1:0] paddr,
	input  logic [lpfd_pkg::PDATA_W-1:0] pwdata,
	lpfd_in_if                           in_ch,
	lpfd_out_if                          out_ch,
	output int                           mismatches,
	output int                           outstanding,
	output int                           payload_seen,
	output int                           markers_seen,
	output int                           errors_seen
);
	import lpfd_pkg::*;

	logic [BYTE_W-1:0]   separator;
	logic                in_payload;
	logic [LEN_BITS-1:0] length_accum;
	logic [LEN_BITS-1:0] bytes_left;
	result_t             pending_results[$];
	int                  bad_count;
	int                  n_payload;
	int                  n_marker;
	int                  n_error;

	function automatic result_t error_result();
		result_t r;
		r = '0;
		r.format_error = 1'b1;
		return r;
	endfunction

	// one stream byte through the framing state; returns 1 when it makes a result
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output result_t r);
		logic [LEN_BITS+3:0] next_len;
		r = '0;
		if (in_payload) begin
			r.out_byte      = b;
			r.has_data      = 1'b1;
			r.end_of_string = (bytes_left <= 1);
			if (bytes_left <= 1) begin
				bytes_left = '0;
				in_payload = 1'b0;
			end else begin
				bytes_left = bytes_left - 1'b1;
			end
			return 1'b1;
		end
		// separator test comes before the digit test
		if (b == separator) begin
			if (length_accum == '0) begin
				r.end_of_string = 1'b1;
				return 1'b1;
			end
			bytes_left   = length_accum;
			length_accum = '0;
			in_payload   = 1'b1;
			return 1'b0;
		end
		if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
			next_len = (LEN_BITS+4)'({4'b0, length_accum} * 10 + (b - CHAR_ZERO));
			if (next_len[LEN_BITS+3:LEN_BITS] != '0) begin
				length_accum = '0;
				r = error_result();
				return 1'b1;
			end
			length_accum = next_len[LEN_BITS-1:0];
			return 1'b0;
		end
		length_accum = '0;
		r = error_result();
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			bad_count++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		result_t predicted;
		if (!arst_n) begin
			separator    = SEPARATOR_RESET;
			in_payload   = 1'b0;
			length_accum = '0;
			bytes_left   = '0;
			pending_results.delete();
			bad_count = 0;
			n_payload = 0;
			n_marker  = 0;
			n_error   = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_SEPARATOR)
				separator = pwdata[BYTE_W-1:0];
			if (in_ch.valid && in_ch.ready) begin
				if (decode_byte(in_ch.in_byte, predicted))
					pending_results.insert(pending_results.size(), predicted);
			end
			if (out_ch.valid && out_ch.ready) begin
				got.out_byte      = out_ch.out_byte;
				got.has_data      = out_ch.has_data;
				got.end_of_string = out_ch.end_of_string;
				got.format_error  = out_ch.format_error;
				if (got.has_data)
					n_payload++;
				else if (got.format_error)
					n_error++;
				else
					n_marker++;
				if (pending_results.size() == 0) begin
					bad_count++;
					$display("%0t: unexpected result, expected none actual %0h", $time, got);
				end else begin
					want = pending_results.pop_front();
					check_field("out_byte", int'(want.out_byte), int'(got.out_byte));
					check_field("has_data", int'(want.has_data), int'(got.has_data));
					check_field("end_of_string", int'(want.end_of_string),
						int'(got.end_of_string));
					check_field("format_error", int'(want.format_error),
						int'(got.format_error));
				end
			end
		end
		mismatches   <= bad_count;
		outstanding  <= pending_results.size();
		payload_seen <= n_payload;
		markers_seen <= n_marker;
		errors_seen  <= n_error;
	end

endmodule

>>> dv/length_prefix_frame_decoder_test.sv
// ----------------------------------------------------------------------------
// length_prefix_frame_decoder_test
// Drives framed and malformed byte streams under several separator settings
// with random gaps and backpressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefix_frame_decoder_test;
	import lpfd_pkg::*;

	localparam int LIMIT_CYCLES  = 300000;
	localparam int DRAIN_CYCLES  = 6;
	localparam int CHOKE_CYCLES  = 120;
	localparam int ITEMS_TARGET  = 700;
	localparam int NUM_SETTINGS  = 6;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatches;
	int outstanding;
	int payload_seen;
	int markers_seen;
	int errors_seen;

	int                bytes_sent;
	int                cycles;
	bit                idle_on;
	bit                choke_req;
	logic [BYTE_W-1:0] cur_sep;

	lpfd_in_if  in_ch();
	lpfd_out_if out_ch();

	length_prefix_frame_decoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	length_prefix_frame_decoder_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.payload_seen (payload_seen),
		.markers_seen (markers_seen),
		.errors_seen  (errors_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
			$display("length_prefix_frame_decoder test failed");
			$finish;
		end
	end

	// result side: random stalls per item, plus one long hold-off on request
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (choke_req) begin
				choke_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end else begin
				stall = idle_on ? $urandom_range(0, 6) : 0;
				if (stall != 0) begin
					out_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [BYTE_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {{(PDATA_W-BYTE_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	// let in-flight bytes settle so the separator can be changed safely
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic bit is_digit(input logic [BYTE_W-1:0] b);
		return b >= CHAR_ZERO && b <= CHAR_NINE;
	endfunction

	function automatic logic [BYTE_W-1:0] bad_char();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(0, 255)); while (is_digit(b) || b == cur_sep);
		return b;
	endfunction

	task automatic send_length(input int len, input bit lead_zero);
		string digits;
		digits = $sformatf("%0d", len);
		if (lead_zero)
			send_byte(CHAR_ZERO);
		for (int i = 0; i < digits.len(); i++)
			send_byte(digits[i]);
	endtask

	function automatic int pick_len();
		int len;
		bit clash;
		do begin
			case ($urandom_range(0, 15))
				0:       len = 0;
				1:       len = $urandom_range(13, 60);
				default: len = $urandom_range(1, 12);
			endcase
			// a digit separator inside the length would cut the field short
			clash = 1'b0;
			if (is_digit(cur_sep)) begin
				string digits;
				digits = $sformatf("%0d", len);
				for (int i = 0; i < digits.len(); i++)
					if (digits[i] == cur_sep)
						clash = 1'b1;
				if (cur_sep == CHAR_ZERO && len == 0)
					clash = 1'b1;
			end
		end while (clash);
		return len;
	endfunction

	task automatic send_frame(input int len);
		logic [BYTE_W-1:0] b;
		send_length(len, $urandom_range(0, 5) == 0 && cur_sep != CHAR_ZERO);
		send_byte(cur_sep);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 7))
				0:       b = cur_sep;
				1:       b = BYTE_W'(CHAR_ZERO + $urandom_range(0, 9));
				default: b = BYTE_W'($urandom_range(0, 255));
			endcase
			send_byte(b);
		end
	endtask

	task automatic random_stream(input int count);
		int stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			case ($urandom_range(0, 9))
				7: send_byte(BYTE_W'($urandom_range(0, 255)));
				8: begin
					// broken length field
					send_length($urandom_range(0, 99), 1'b0);
					send_byte(bad_char());
				end
				9: begin
					// too many digits for the length counter
					send_byte(BYTE_W'(CHAR_ZERO + $urandom_range(1, 9)));
					repeat (5) send_byte(BYTE_W'(CHAR_ZERO + $urandom_range(0, 9)));
				end
				default: send_frame(pick_len());
			endcase
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] settings[NUM_SETTINGS];
		arst_n        = 1'b0;
		idle_on       = 1'b0;
		choke_req     = 1'b0;
		bytes_sent    = 0;
		cycles        = 0;
		cur_sep       = SEPARATOR_RESET;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		in_ch.valid   <= 1'b0;
		in_ch.in_byte <= '0;
		settings[0] = SEPARATOR_RESET;
		settings[1] = 8'h00;
		settings[2] = 8'hff;
		settings[3] = BYTE_W'(CHAR_ZERO + 5);
		settings[4] = BYTE_W'($urandom_range(0, 255));
		settings[5] = SEPARATOR_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty string, payload holding separator and digit, bad chars,
		// length at the counter limit then overflow, leading zero, byte extremes
		idle_on = 1'b1;
		send_byte(cur_sep);
		send_byte("3");
		send_byte(cur_sep);
		send_byte("a");
		send_byte(cur_sep);
		send_byte("9");
		send_byte("x");
		send_byte("6");
		send_byte("5");
		send_byte("5");
		send_byte("3");
		send_byte("5");
		send_byte("0");
		send_byte("0");
		send_byte(cur_sep);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte("1");
		send_byte(cur_sep);
		send_byte(8'hff);
		send_byte("2");
		send_byte(cur_sep);
		send_byte(8'h00);
		send_byte(8'h7f);

		// long output hold-off while the input keeps coming
		idle_on   = 1'b0;
		choke_req = 1'b1;
		send_frame(40);
		idle_on = 1'b1;

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			wait_idle();
			cur_sep = settings[s];
			apb_write(ADDR_SEPARATOR, cur_sep);
			// one setting runs with no idling at all
			idle_on = (s != 1);
			random_stream(ITEMS_TARGET / NUM_SETTINGS);
		end
		wait_idle();

		$display("sent %0d stream bytes across %0d separator settings incl. 0x00, 0xff, a digit",
			bytes_sent, NUM_SETTINGS);
		$display("checked %0d payload bytes, %0d empty-string markers, %0d format errors",
			payload_seen, markers_seen, errors_seen);
		if (mismatches == 0) begin
			$display("length_prefix_frame_decoder test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("length_prefix_frame_decoder test failed");
		end
		$finish;
	end

endmodule

>>> files.f
design/lpfd_pkg.sv
design/lpfd_if.sv
design/lpfd_cfg_regs.sv
design/lpfd_parse.sv
design/lpfd_out_reg.sv
design/length_prefix_frame_decoder.sv
dv/length_prefix_frame_decoder_checker.sv
dv/length_prefix_frame_decoder_test.sv
